### design/assert_macros.svh
// Assertion macros used by the checker file of the row unpacker.
// Needs nothing else; include this header before writing any assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property is checked at every clock edge and is disabled while reset is asserted.
`define MRGBU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The property is checked at every clock edge, reset cycles included.
`define MRGBU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### design/mrgbu_pkg.sv
// Types, register codes, reset values and the mask decoder of the row unpacker.
// Used by the top level, the channel scaler and the checker; depends on nothing.
package mrgbu_pkg;

  localparam int COL_W = 12;

  typedef enum logic [2:0] {
    CFG_BYTES_PER_PIXEL = 3'd0,
    CFG_ROW_PITCH       = 3'd1,
    CFG_ROW_WIDTH       = 3'd2,
    CFG_RED_MASK        = 3'd3,
    CFG_GREEN_MASK      = 3'd4,
    CFG_BLUE_MASK       = 3'd5,
    CFG_ALPHA_MASK      = 3'd6,
    CFG_ALPHA_ENABLE    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       red_value;
    logic [7:0]       green_value;
    logic [7:0]       blue_value;
    logic [7:0]       alpha_value;
    logic [COL_W-1:0] pixel_column;
    logic             row_end;
    logic             format_error;
  } out_res_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;
    logic [15:0] coef;
    logic        bad;
  } mask_info_t;

  localparam logic [15:0] SCALE_TABLE [8] = '{
    16'hff00, 16'h5500, 16'h2480, 16'h1100,
    16'h0840, 16'h0410, 16'h0204, 16'h0100
  };

  localparam logic [1:0]  RST_BPP_LAST   = 2'd3;
  localparam int          RST_PITCH      = 16384;
  localparam int          RST_WIDTH      = 4096;
  localparam logic [31:0] RED_MASK_RST   = 32'h00ff_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_ff00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00ff;
  localparam logic [31:0] ALPHA_MASK_RST = 32'hff00_0000;
  localparam logic        RST_ALPHA_EN   = 1'b1;

  // Finds the field position, its run of ones and the matching scale coefficient.
  function automatic mask_info_t mask_decode(logic [31:0] m);
    mask_info_t  info;
    logic [31:0] t;
    logic [4:0]  sh;
    logic        found;
    logic [3:0]  run;
    logic        stop;
    sh    = '0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && m[i]) begin
        sh    = 5'(i);
        found = 1'b1;
      end
    end
    t    = m >> sh;
    run  = '0;
    stop = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (!stop && t[i]) begin
        run = run + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    info.mask  = m;
    info.shift = sh;
    info.bad   = (m == 32'd0) || (run > 4'd8);
    info.coef  = info.bad ? 16'd0 : SCALE_TABLE[3'(run - 4'd1)];
    return info;
  endfunction

endpackage

### design/masked_rgb_row_unpacker_unit.sv
// Bitmask-RGB row unpacker: one raw byte per request, one ARGB result per finished pixel.
// A pixel result is registered in stage 1 and then in the output register before out_valid.
// Throughput is one byte per cycle while in_ready is high; the byte counters update in the accept cycle.
// Synchronous active-low reset clears the counters and the pipeline valid bits
// and loads the default register values. Depends on mrgbu_pkg and mrgbu_chan.
module masked_rgb_row_unpacker_unit #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_PITCH = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrgbu_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrgbu_pkg::out_res_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_PITCH + 1);
  localparam logic [31:0] WIDTH_LIM = 32'(MAX_WIDTH);
  localparam logic [31:0] PITCH_LIM = 32'(MAX_PITCH);
  localparam int RST_W = (MAX_WIDTH < mrgbu_pkg::RST_WIDTH) ? MAX_WIDTH : mrgbu_pkg::RST_WIDTH;
  localparam int RST_P = (MAX_PITCH < mrgbu_pkg::RST_PITCH) ? MAX_PITCH : mrgbu_pkg::RST_PITCH;

  logic [1:0]            bpp_last_r;
  logic [PW-1:0]         pitch_r;
  logic [WW-1:0]         width_r;
  mrgbu_pkg::mask_info_t red_info_r;
  mrgbu_pkg::mask_info_t green_info_r;
  mrgbu_pkg::mask_info_t blue_info_r;
  mrgbu_pkg::mask_info_t alpha_info_r;
  logic                  alpha_en_r;

  logic [1:0]            bpp_last_wr;
  logic [31:0]           pitch_raw;
  logic [31:0]           width_raw;
  logic [PW-1:0]         pitch_wr;
  logic [WW-1:0]         width_wr;
  mrgbu_pkg::mask_info_t mask_wr;

  logic [23:0]   gather_r;
  logic [1:0]    bip_r;
  logic [PW-1:0] bir_r;
  logic [WW-1:0] col_r;
  logic [23:0]   gather_nxt;
  logic [1:0]    bip_nxt;
  logic [PW-1:0] bir_nxt;
  logic [WW-1:0] col_nxt;

  logic [23:0]   gather_cur;
  logic [1:0]    bip_cur;
  logic [PW-1:0] bir_cur;
  logic [WW-1:0] col_cur;
  logic [PW-1:0] bir_inc;
  logic [31:0]   word;
  logic          emit;
  logic          row_end;

  logic                in_fire;
  logic                s1_free;
  logic                out_free;
  logic                s1_valid_r;
  logic [31:0]         s1_word_r;
  logic [WW-1:0]       s1_col_r;
  logic                s1_row_end_r;
  logic                out_valid_r;
  mrgbu_pkg::out_res_t out_data_r;
  mrgbu_pkg::out_res_t res_nxt;

  logic [7:0] red_val;
  logic [7:0] green_val;
  logic [7:0] blue_val;
  logic [7:0] alpha_val;
  logic       bad;

  always_comb begin
    bpp_last_wr = (cfg_data[2:0] < 3'd2) ? 2'd1 :
                  (cfg_data[2:0] > 3'd4) ? 2'd3 : 2'(cfg_data[2:0] - 3'd1);
    pitch_raw   = 32'(cfg_data[14:0]);
    width_raw   = 32'(cfg_data[12:0]);
    pitch_wr    = (pitch_raw == 32'd0) ? PW'(1) :
                  (pitch_raw > PITCH_LIM) ? PW'(PITCH_LIM) : PW'(pitch_raw);
    width_wr    = (width_raw == 32'd0) ? WW'(1) :
                  (width_raw > WIDTH_LIM) ? WW'(WIDTH_LIM) : WW'(width_raw);
    mask_wr     = mrgbu_pkg::mask_decode(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_last_r   <= mrgbu_pkg::RST_BPP_LAST;
      pitch_r      <= PW'(RST_P);
      width_r      <= WW'(RST_W);
      red_info_r   <= mrgbu_pkg::mask_decode(mrgbu_pkg::RED_MASK_RST);
      green_info_r <= mrgbu_pkg::mask_decode(mrgbu_pkg::GREEN_MASK_RST);
      blue_info_r  <= mrgbu_pkg::mask_decode(mrgbu_pkg::BLUE_MASK_RST);
      alpha_info_r <= mrgbu_pkg::mask_decode(mrgbu_pkg::ALPHA_MASK_RST);
      alpha_en_r   <= mrgbu_pkg::RST_ALPHA_EN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrgbu_pkg::CFG_BYTES_PER_PIXEL: bpp_last_r   <= bpp_last_wr;
        mrgbu_pkg::CFG_ROW_PITCH:       pitch_r      <= pitch_wr;
        mrgbu_pkg::CFG_ROW_WIDTH:       width_r      <= width_wr;
        mrgbu_pkg::CFG_RED_MASK:        red_info_r   <= mask_wr;
        mrgbu_pkg::CFG_GREEN_MASK:      green_info_r <= mask_wr;
        mrgbu_pkg::CFG_BLUE_MASK:       blue_info_r  <= mask_wr;
        mrgbu_pkg::CFG_ALPHA_MASK:      alpha_info_r <= mask_wr;
        mrgbu_pkg::CFG_ALPHA_ENABLE:    alpha_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    gather_cur = in_data.frame_start ? 24'd0 : gather_r;
    bip_cur    = in_data.frame_start ? 2'd0 : bip_r;
    bir_cur    = in_data.frame_start ? '0 : bir_r;
    col_cur    = in_data.frame_start ? '0 : col_r;
    gather_nxt = gather_cur;
    bip_nxt    = bip_cur;
    col_nxt    = col_cur;
    emit       = 1'b0;
    word       = 32'(gather_cur) | (32'(in_data.stream_byte) << {bpp_last_r, 3'b000});
    row_end    = (col_cur == width_r - WW'(1));
    if (col_cur < width_r) begin
      if (bip_cur >= bpp_last_r) begin
        emit       = 1'b1;
        col_nxt    = col_cur + WW'(1);
        bip_nxt    = 2'd0;
        gather_nxt = 24'd0;
      end else begin
        gather_nxt = 24'(32'(gather_cur) | (32'(in_data.stream_byte) << {bip_cur, 3'b000}));
        bip_nxt    = bip_cur + 2'd1;
      end
    end
    bir_inc = bir_cur + PW'(1);
    bir_nxt = bir_inc;
    if (bir_inc >= pitch_r) begin
      gather_nxt = 24'd0;
      bip_nxt    = 2'd0;
      bir_nxt    = '0;
      col_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r    <= 24'd0;
      bip_r       <= 2'd0;
      bir_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        gather_r <= gather_nxt;
        bip_r    <= bip_nxt;
        bir_r    <= bir_nxt;
        col_r    <= col_nxt;
      end
      if (s1_free) begin
        s1_valid_r <= in_fire && emit;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      s1_word_r    <= word;
      s1_col_r     <= col_cur;
      s1_row_end_r <= row_end;
    end
    if (out_free && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  mrgbu_chan u_red (
    .word  (s1_word_r),
    .info  (red_info_r),
    .value (red_val)
  );

  mrgbu_chan u_green (
    .word  (s1_word_r),
    .info  (green_info_r),
    .value (green_val)
  );

  mrgbu_chan u_blue (
    .word  (s1_word_r),
    .info  (blue_info_r),
    .value (blue_val)
  );

  mrgbu_chan u_alpha (
    .word  (s1_word_r),
    .info  (alpha_info_r),
    .value (alpha_val)
  );

  always_comb begin
    bad                  = red_info_r.bad || green_info_r.bad || blue_info_r.bad ||
                           (alpha_en_r && alpha_info_r.bad);
    res_nxt.red_value    = bad ? 8'd0 : red_val;
    res_nxt.green_value  = bad ? 8'd0 : green_val;
    res_nxt.blue_value   = bad ? 8'd0 : blue_val;
    res_nxt.alpha_value  = (bad || !alpha_en_r) ? 8'd0 : alpha_val;
    res_nxt.pixel_column = mrgbu_pkg::COL_W'(s1_col_r);
    res_nxt.row_end      = s1_row_end_r;
    res_nxt.format_error = bad;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/mrgbu_chan.sv
// One color channel: mask, align and scale the field of a pixel word to 8 bits.
// Depends on mrgbu_pkg for the decoded mask type.
module mrgbu_chan (
  input  logic [31:0]            word,
  input  mrgbu_pkg::mask_info_t  info,
  output logic [7:0]             value
);

  logic [31:0] field;
  logic [31:0] prod;

  // Only the low 16 bits of the field reach bits 15:8 of the product.
  always_comb begin
    field = (word & info.mask) >> info.shift;
    prod  = 32'(field[15:0]) * 32'(info.coef);
    value = prod[15:8];
  end

endmodule

### design/mrgbu_checker.sv
// Port-level checks of the row unpacker result channel, bound to the top level.
// Depends on mrgbu_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module mrgbu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mrgbu_pkg::out_res_t out_data
);

  logic chan_zero;

  assign chan_zero = (out_data.red_value == 8'd0) && (out_data.green_value == 8'd0) &&
                     (out_data.blue_value == 8'd0) && (out_data.alpha_value == 8'd0);

  `MRGBU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `MRGBU_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data))
  `MRGBU_ASSERT(a_err_zero, clk, rst_n, out_valid && out_data.format_error |-> chan_zero)
  `MRGBU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind masked_rgb_row_unpacker_unit mrgbu_checker u_mrgbu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
